[rtl/core/hrldu_pkg.sv]
// shared types, codes and delta tables of the reference list and eviction unit
package hrldu_pkg;

  // field widths
  localparam int unsigned POC_W = 31;
  localparam int unsigned LVL_W = 3;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned TOT_W = 6;
  localparam int unsigned KEY_W = 2 * POC_W;
  localparam int unsigned BUF_DEPTH = 4;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_EVICT = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_LOW_DELAY = 2'd1;
  localparam logic [1:0] MODE_RANDOM    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LDT,
    S_PREP,
    S_RALOAD,
    S_RANEXT,
    S_SCAN,
    S_POST,
    S_N1P,
    S_N1Q,
    S_OUT
  } ctl_state_e;

  typedef enum logic [3:0] {
    PH_EV1,
    PH_EV2,
    PH_LDP,
    PH_LDF,
    PH_N0,
    PH_N1,
    PH_L2A,
    PH_L2B,
    PH_RA0,
    PH_RASP,
    PH_RA1
  } phase_e;

  typedef enum logic [2:0] {
    PRED_BELOW,
    PRED_ABOVE,
    PRED_NEAR0,
    PRED_NEAR1,
    PRED_L2,
    PRED_ODD,
    PRED_VALID,
    PRED_MATCH
  } scan_pred_e;

  typedef enum logic [1:0] {
    KEY_DIST,
    KEY_DIST_POC,
    KEY_POC
  } scan_key_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_DEFAULT,
    EMIT_EMPTY,
    EMIT_EVICT,
    EMIT_LIST
  } emit_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       wr;
    logic       scan_init;
    logic       scan_step;
    scan_pred_e pred;
    scan_key_e  key;
    logic       prep_step;
    logic       ra_load;
    logic       used_clr;
    logic       used_mark;
    logic       push;
    logic       push_sel;
    logic       push_n1;
    logic       n1_save;
    logic       cnt_clr;
    logic       ld_init;
    logic       ld_next;
    logic       ld_fb;
    logic       ld_tgt;
    emit_e      emit;
    logic       emit_sel;
    logic       emit_buf;
  } dp_ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic idx_last;
    logic best_found;
    logic lvl_is2;
    logic m0_gt1;
    logic n1_have;
    logic k_lt_a;
    logic k_lt_n0;
    logic k_lt_tot;
    logic k_last;
    logic tot_zero;
    logic ld_more_p;
    logic ld_more_f;
    logic n0_lt_m0;
  } dp_stat_t;

  typedef logic signed [5:0] delta_t;

  localparam delta_t LD_PRIMARY [4][3] = '{
    '{-6'sd1, -6'sd4,  -6'sd8},
    '{-6'sd1, -6'sd13, -6'sd25},
    '{-6'sd1, -6'sd10, -6'sd22},
    '{-6'sd1, -6'sd11, -6'sd23}
  };

  localparam delta_t LD_FALLBACK [4][3] = '{
    '{-6'sd1, -6'sd4, -6'sd8},
    '{-6'sd1, -6'sd5, -6'sd9},
    '{-6'sd1, -6'sd2, -6'sd6},
    '{-6'sd1, -6'sd3, -6'sd7}
  };

  // poc delta of one low-delay pattern step
  function automatic delta_t ld_delta(input logic fb, input logic [1:0] cyc,
                                      input logic [1:0] k);
    delta_t d;
    if (k == 2'd3) begin
      d = '0;
    end else if (fb) begin
      d = LD_FALLBACK[cyc][k];
    end else begin
      d = LD_PRIMARY[cyc][k];
    end
    return d;
  endfunction

endpackage

[rtl/core/hrldu_dpath.sv]
// datapath: slot table, scan and compare unit, list counters and result register
module hrldu_dpath
  import hrldu_pkg::*;
#(
  parameter int DPB_SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_ctl_t          ctl_i,
  output dp_stat_t         stat_o,
  input  logic [3:0]       slot_i,
  input  logic             entry_valid_i,
  input  logic [POC_W-1:0] frame_poc_i,
  input  logic [LVL_W-1:0] frame_level_i,
  input  logic [LVL_W-1:0] frame_temporal_id_i,
  input  logic [CNT_W-1:0] max_list0_i,
  input  logic [CNT_W-1:0] max_list1_i,
  output logic             result_valid_o,
  output logic             list_select_o,
  output logic [3:0]       ref_slot_o,
  output logic             entry_found_o,
  output logic             use_default_o,
  output logic             last_o,
  output logic [CNT_W-1:0] list0_count_o,
  output logic [CNT_W-1:0] list1_count_o
);

  localparam int unsigned IW = $clog2(DPB_SLOTS);

  // slot table
  logic [DPB_SLOTS-1:0] valid_q;
  logic [POC_W-1:0]     poc_q [DPB_SLOTS];
  logic [LVL_W-1:0]     lvl_q [DPB_SLOTS];
  logic [LVL_W-1:0]     tid_q [DPB_SLOTS];

  // per-slot distance and side, filled by the prep pass
  logic [POC_W-1:0]     dist_q [DPB_SLOTS];
  logic [DPB_SLOTS-1:0] below_q;
  logic [DPB_SLOTS-1:0] above_q;
  logic [DPB_SLOTS-1:0] used_q;

  // current frame
  logic [POC_W-1:0] cur_poc_q;
  logic [LVL_W-1:0] cur_lvl_q;
  logic [LVL_W-1:0] cur_tid_q;
  logic [CNT_W-1:0] m0_q;
  logic [CNT_W-1:0] m1_q;

  // scan state
  logic [IW-1:0]    idx_q;
  logic             best_found_q;
  logic [IW-1:0]    best_slot_q;
  logic [KEY_W-1:0] best_key_q;

  // counters
  logic [CNT_W-1:0] cnt_b_q, cnt_a_q, ra_a_q, n0_q, n1_q;
  logic [TOT_W-1:0] k_q;
  logic [1:0]       ld_k_q;
  logic [POC_W-1:0] tgt_q;
  logic             tgt_ok_q;
  logic             n1_have_q;
  logic [IW-1:0]    n1_slot_q;
  logic [IW-1:0]    buf_slot_q [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] buf_sel_q;

  // result register
  logic             res_valid_q;
  logic             res_sel_q;
  logic [3:0]       res_slot_q;
  logic             res_found_q;
  logic             res_dflt_q;
  logic             res_last_q;
  logic [CNT_W-1:0] res_c0_q, res_c1_q;

  // entry read at the scan index
  logic             rd_valid, rd_tid_ok, rd_below, rd_above, rd_used, rd_lvl0;
  logic [POC_W-1:0] rd_poc, rd_dist;
  logic [LVL_W-1:0] rd_lvl;
  logic             grp01, pred_hit, take;
  logic [KEY_W-1:0] cand_key;
  logic [TOT_W-1:0] tot;

  assign rd_valid  = valid_q[idx_q];
  assign rd_poc    = poc_q[idx_q];
  assign rd_lvl    = lvl_q[idx_q];
  assign rd_dist   = dist_q[idx_q];
  assign rd_below  = below_q[idx_q];
  assign rd_above  = above_q[idx_q];
  assign rd_used   = used_q[idx_q];
  assign rd_tid_ok = tid_q[idx_q] <= cur_tid_q;
  assign grp01     = cur_lvl_q <= LVL_W'(1);
  assign rd_lvl0   = !grp01 || (rd_lvl == '0);
  assign tot       = TOT_W'(n0_q) + TOT_W'(n1_q);

  // candidate filter
  always_comb begin
    case (ctl_i.pred)
      PRED_BELOW: pred_hit = rd_valid && rd_tid_ok && rd_lvl0 && rd_below && !rd_used;
      PRED_ABOVE: pred_hit = rd_valid && rd_tid_ok && rd_lvl0 && rd_above && !rd_used;
      PRED_NEAR0: pred_hit = rd_valid && rd_tid_ok && (rd_lvl <= LVL_W'(1)) && rd_below;
      PRED_NEAR1: pred_hit = rd_valid && rd_tid_ok && (rd_lvl <= LVL_W'(1)) && rd_above;
      PRED_L2: pred_hit = rd_valid && rd_tid_ok && (rd_lvl == LVL_W'(2))
                          && (rd_below || rd_above) && !rd_used;
      PRED_ODD:   pred_hit = rd_valid && (rd_poc[1:0] != 2'd0);
      PRED_VALID: pred_hit = rd_valid;
      PRED_MATCH: pred_hit = rd_valid && tgt_ok_q && (rd_poc == tgt_q);
      default:    pred_hit = 1'b0;
    endcase
  end

  // sort key
  always_comb begin
    case (ctl_i.key)
      KEY_DIST:     cand_key = {rd_dist, {POC_W{1'b0}}};
      KEY_DIST_POC: cand_key = {rd_dist, rd_poc};
      default:      cand_key = {rd_poc, {POC_W{1'b0}}};
    endcase
  end

  // strict compare keeps the lower slot on a tie
  assign take = pred_hit && (!best_found_q || (cand_key < best_key_q));

  // slot table write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr && (32'(slot_i) < DPB_SLOTS)) begin
      valid_q[slot_i[IW-1:0]] <= entry_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && (32'(slot_i) < DPB_SLOTS)) begin
      poc_q[slot_i[IW-1:0]] <= frame_poc_i;
      lvl_q[slot_i[IW-1:0]] <= frame_level_i;
      tid_q[slot_i[IW-1:0]] <= frame_temporal_id_i;
    end
  end

  // prep pass: distance and side of one slot a cycle
  logic [POC_W-1:0] sub_cp, sub_pc;
  logic             prep_below, prep_above, prep_cand;
  assign sub_cp     = cur_poc_q - rd_poc;
  assign sub_pc     = rd_poc - cur_poc_q;
  assign prep_below = rd_poc < cur_poc_q;
  assign prep_above = rd_poc > cur_poc_q;
  assign prep_cand  = rd_valid && rd_tid_ok && rd_lvl0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.prep_step) begin
      dist_q[idx_q]  <= prep_below ? sub_cp : sub_pc;
      below_q[idx_q] <= prep_below;
      above_q[idx_q] <= prep_above;
    end
  end

  // current frame latch
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cur_poc_q <= frame_poc_i;
      cur_lvl_q <= frame_level_i;
      cur_tid_q <= frame_temporal_id_i;
      m0_q      <= max_list0_i;
      m1_q      <= max_list1_i;
    end
  end

  // scan index and best candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      best_found_q <= 1'b0;
      best_slot_q  <= '0;
      best_key_q   <= '0;
    end else if (ctl_i.scan_init) begin
      idx_q        <= '0;
      best_found_q <= 1'b0;
    end else if (ctl_i.scan_step || ctl_i.prep_step) begin
      idx_q <= idx_q + IW'(1);
      if (ctl_i.scan_step && take) begin
        best_found_q <= 1'b1;
        best_slot_q  <= idx_q;
        best_key_q   <= cand_key;
      end
    end
  end

  // slots already placed in the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctl_i.load || ctl_i.used_clr) begin
      used_q <= '0;
    end else if (ctl_i.used_mark) begin
      used_q[best_slot_q] <= 1'b1;
    end
  end

  // candidate counts, list lengths and emit counter
  logic [CNT_W-1:0] ra_a, ra_b;
  logic [TOT_W-1:0] ra_ab;
  assign ra_a  = (cnt_b_q < m0_q) ? cnt_b_q : m0_q;
  assign ra_b  = (cnt_a_q < m1_q) ? cnt_a_q : m1_q;
  assign ra_ab = TOT_W'(ra_a) + TOT_W'(ra_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_b_q <= '0;
      cnt_a_q <= '0;
      ra_a_q  <= '0;
      n0_q    <= '0;
      n1_q    <= '0;
      k_q     <= '0;
    end else begin
      if (ctl_i.load) begin
        cnt_b_q <= '0;
        cnt_a_q <= '0;
      end else if (ctl_i.prep_step && prep_cand) begin
        if (prep_below) cnt_b_q <= cnt_b_q + CNT_W'(1);
        if (prep_above) cnt_a_q <= cnt_a_q + CNT_W'(1);
      end
      if (ctl_i.load || ctl_i.cnt_clr) begin
        n0_q <= '0;
        n1_q <= '0;
      end else if (ctl_i.ra_load) begin
        ra_a_q <= ra_a;
        n0_q   <= (ra_ab < TOT_W'(m0_q)) ? ra_ab[CNT_W-1:0] : m0_q;
        n1_q   <= ra_b;
      end else if (ctl_i.push) begin
        if (ctl_i.push_sel) n1_q <= n1_q + CNT_W'(1);
        else                n0_q <= n0_q + CNT_W'(1);
      end
      if (ctl_i.load) begin
        k_q <= '0;
      end else if (ctl_i.emit == EMIT_LIST) begin
        k_q <= k_q + TOT_W'(1);
      end
    end
  end

  // short result list for low-delay and level-2 builds
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      buf_slot_q[tot[1:0]] <= ctl_i.push_n1 ? n1_slot_q : best_slot_q;
      buf_sel_q[tot[1:0]]  <= ctl_i.push_sel;
    end
    if (ctl_i.n1_save) begin
      n1_slot_q <= best_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_have_q <= 1'b0;
    end else if (ctl_i.load) begin
      n1_have_q <= 1'b0;
    end else if (ctl_i.n1_save) begin
      n1_have_q <= best_found_q;
    end
  end

  // low-delay pattern step and target poc
  logic signed [POC_W+1:0] tgt;
  assign tgt = $signed({2'b00, cur_poc_q})
             + (POC_W+2)'(ld_delta(ctl_i.ld_fb, cur_poc_q[1:0], ld_k_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_k_q   <= '0;
      tgt_ok_q <= 1'b0;
      tgt_q    <= '0;
    end else begin
      if (ctl_i.ld_init) begin
        ld_k_q <= '0;
      end else if (ctl_i.ld_next) begin
        ld_k_q <= ld_k_q + 2'd1;
      end
      if (ctl_i.ld_tgt) begin
        tgt_ok_q <= !tgt[POC_W+1];
        tgt_q    <= tgt[POC_W-1:0];
      end
    end
  end

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.emit != EMIT_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.emit)
      EMIT_DEFAULT, EMIT_EMPTY: begin
        res_sel_q   <= 1'b0;
        res_slot_q  <= '0;
        res_found_q <= 1'b0;
        res_dflt_q  <= ctl_i.emit == EMIT_DEFAULT;
        res_last_q  <= 1'b1;
        res_c0_q    <= '0;
        res_c1_q    <= '0;
      end
      EMIT_EVICT: begin
        res_sel_q   <= 1'b0;
        res_slot_q  <= best_found_q ? 4'(best_slot_q) : 4'd0;
        res_found_q <= best_found_q;
        res_dflt_q  <= 1'b0;
        res_last_q  <= 1'b1;
        res_c0_q    <= '0;
        res_c1_q    <= '0;
      end
      EMIT_LIST: begin
        res_sel_q   <= ctl_i.emit_buf ? buf_sel_q[k_q[1:0]] : ctl_i.emit_sel;
        res_slot_q  <= ctl_i.emit_buf ? 4'(buf_slot_q[k_q[1:0]]) : 4'(best_slot_q);
        res_found_q <= 1'b1;
        res_dflt_q  <= 1'b0;
        res_last_q  <= (k_q + TOT_W'(1)) == tot;
        res_c0_q    <= n0_q;
        res_c1_q    <= n1_q;
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign list_select_o  = res_sel_q;
  assign ref_slot_o     = res_slot_q;
  assign entry_found_o  = res_found_q;
  assign use_default_o  = res_dflt_q;
  assign last_o         = res_last_q;
  assign list0_count_o  = res_c0_q;
  assign list1_count_o  = res_c1_q;

  // status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.idx_last   = idx_q == IW'(DPB_SLOTS - 1);
    stat_o.best_found = best_found_q;
    stat_o.lvl_is2    = cur_lvl_q == LVL_W'(2);
    stat_o.m0_gt1     = m0_q > CNT_W'(1);
    stat_o.n1_have    = n1_have_q;
    stat_o.k_lt_a     = k_q < TOT_W'(ra_a_q);
    stat_o.k_lt_n0    = k_q < TOT_W'(n0_q);
    stat_o.k_lt_tot   = k_q < tot;
    stat_o.k_last     = (k_q + TOT_W'(1)) == tot;
    stat_o.tot_zero   = tot == '0;
    stat_o.ld_more_p  = (ld_k_q != 2'd3) && (CNT_W'(ld_k_q) < m0_q);
    stat_o.ld_more_f  = (ld_k_q != 2'd3) && (n0_q < m0_q);
    stat_o.n0_lt_m0   = n0_q < m0_q;
  end

  // a streamed list entry always has a scan winner
  a_list_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.emit == EMIT_LIST) && !ctl_i.emit_buf |-> best_found_q)
    else $error("list beat without a selected slot");

  // short list never overflows
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> (tot < TOT_W'(BUF_DEPTH)))
    else $error("short list overflow");

  // a found entry never carries the default flag
  a_found_dflt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_found_q && res_dflt_q))
    else $error("found and default both set");

endmodule

[rtl/core/hrldu_ctrl.sv]
// controller: command decode, scan sequencing and result emission
module hrldu_ctrl
  import hrldu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] command_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  dp_stat_t   stat_i,
  output dp_ctl_t    ctl_o,
  output logic       busy_o
);

  ctl_state_e state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] mode_q;
  logic       mode_on;

  assign busy_o  = state_q != S_IDLE;
  assign mode_on = (mode_q == MODE_LOW_DELAY) || (mode_q == MODE_RANDOM);

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_EV2;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    phase_d = phase_q;

    // filter and key follow the phase
    case (phase_q)
      PH_RA0: begin
        ctl_o.pred = PRED_BELOW;
        ctl_o.key  = KEY_DIST;
      end
      PH_RASP, PH_RA1: begin
        ctl_o.pred = PRED_ABOVE;
        ctl_o.key  = KEY_DIST;
      end
      PH_N0: begin
        ctl_o.pred = PRED_NEAR0;
        ctl_o.key  = KEY_DIST;
      end
      PH_N1: begin
        ctl_o.pred = PRED_NEAR1;
        ctl_o.key  = KEY_DIST;
      end
      PH_L2A, PH_L2B: begin
        ctl_o.pred = PRED_L2;
        ctl_o.key  = KEY_DIST_POC;
      end
      PH_EV1: begin
        ctl_o.pred = PRED_ODD;
        ctl_o.key  = KEY_POC;
      end
      PH_LDP, PH_LDF: begin
        ctl_o.pred = PRED_MATCH;
        ctl_o.key  = KEY_POC;
      end
      default: begin
        ctl_o.pred = PRED_VALID;
        ctl_o.key  = KEY_POC;
      end
    endcase
    ctl_o.ld_fb = phase_q == PH_LDF;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          case (command_i)
            CMD_WRITE: ctl_o.wr = 1'b1;
            CMD_BUILD, CMD_EVICT: begin
              if (!mode_on) begin
                ctl_o.emit = EMIT_DEFAULT;
              end else if (command_i == CMD_EVICT) begin
                ctl_o.scan_init = 1'b1;
                phase_d = (mode_q == MODE_LOW_DELAY) ? PH_EV1 : PH_EV2;
                state_d = S_SCAN;
              end else if (mode_q == MODE_LOW_DELAY) begin
                ctl_o.ld_init = 1'b1;
                phase_d = PH_LDP;
                state_d = S_LDT;
              end else begin
                ctl_o.scan_init = 1'b1;
                state_d = S_PREP;
              end
            end
            default: ;
          endcase
        end
      end
      // next low-delay lookup or done
      S_LDT: begin
        if ((phase_q == PH_LDP) ? stat_i.ld_more_p : stat_i.ld_more_f) begin
          ctl_o.ld_tgt    = 1'b1;
          ctl_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_PREP: begin
        ctl_o.prep_step = 1'b1;
        if (stat_i.idx_last) begin
          if (stat_i.lvl_is2) begin
            ctl_o.scan_init = 1'b1;
            phase_d = PH_N0;
            state_d = S_SCAN;
          end else begin
            state_d = S_RALOAD;
          end
        end
      end
      S_RALOAD: begin
        ctl_o.ra_load = 1'b1;
        state_d = S_RANEXT;
      end
      // pick the list part of the next streamed entry
      S_RANEXT: begin
        if (stat_i.tot_zero) begin
          ctl_o.emit = EMIT_EMPTY;
          state_d = S_IDLE;
        end else if (stat_i.k_lt_a) begin
          ctl_o.scan_init = 1'b1;
          phase_d = PH_RA0;
          state_d = S_SCAN;
        end else if (stat_i.k_lt_n0) begin
          ctl_o.scan_init = 1'b1;
          phase_d = PH_RASP;
          state_d = S_SCAN;
        end else if (stat_i.k_lt_tot) begin
          ctl_o.used_clr  = phase_q != PH_RA1;
          ctl_o.scan_init = 1'b1;
          phase_d = PH_RA1;
          state_d = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_POST;
        end
      end
      // act on the scan winner
      S_POST: begin
        case (phase_q)
          PH_EV1: begin
            if (stat_i.best_found) begin
              ctl_o.emit = EMIT_EVICT;
              state_d = S_IDLE;
            end else begin
              ctl_o.scan_init = 1'b1;
              phase_d = PH_EV2;
              state_d = S_SCAN;
            end
          end
          PH_EV2: begin
            ctl_o.emit = EMIT_EVICT;
            state_d = S_IDLE;
          end
          PH_LDP: begin
            if (stat_i.best_found) begin
              ctl_o.push    = 1'b1;
              ctl_o.ld_next = 1'b1;
            end else begin
              ctl_o.cnt_clr = 1'b1;
              ctl_o.ld_init = 1'b1;
              phase_d = PH_LDF;
            end
            state_d = S_LDT;
          end
          PH_LDF: begin
            ctl_o.push    = stat_i.best_found;
            ctl_o.ld_next = 1'b1;
            state_d = S_LDT;
          end
          PH_N0: begin
            ctl_o.push      = stat_i.best_found;
            ctl_o.scan_init = 1'b1;
            phase_d = PH_N1;
            state_d = S_SCAN;
          end
          PH_N1: begin
            ctl_o.n1_save = 1'b1;
            if (stat_i.m0_gt1) begin
              ctl_o.scan_init = 1'b1;
              phase_d = PH_L2A;
              state_d = S_SCAN;
            end else begin
              state_d = S_N1P;
            end
          end
          PH_L2A: begin
            ctl_o.used_mark = stat_i.best_found;
            ctl_o.scan_init = 1'b1;
            phase_d = PH_L2B;
            state_d = S_SCAN;
          end
          PH_L2B: begin
            ctl_o.push = stat_i.best_found;
            state_d = S_N1P;
          end
          default: begin
            ctl_o.emit      = EMIT_LIST;
            ctl_o.emit_sel  = phase_q == PH_RA1;
            ctl_o.used_mark = 1'b1;
            state_d = S_RANEXT;
          end
        endcase
      end
      // spill the nearest later picture into list 0
      S_N1P: begin
        if (stat_i.n1_have && stat_i.n0_lt_m0) begin
          ctl_o.push    = 1'b1;
          ctl_o.push_n1 = 1'b1;
        end
        state_d = S_N1Q;
      end
      S_N1Q: begin
        if (stat_i.n1_have) begin
          ctl_o.push     = 1'b1;
          ctl_o.push_sel = 1'b1;
          ctl_o.push_n1  = 1'b1;
        end
        state_d = S_OUT;
      end
      // play out the short list
      S_OUT: begin
        if (stat_i.tot_zero) begin
          ctl_o.emit = EMIT_EMPTY;
          state_d = S_IDLE;
        end else begin
          ctl_o.emit     = EMIT_LIST;
          ctl_o.emit_buf = 1'b1;
          if (stat_i.k_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the sequencer leaves idle only on an accepted beat
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && $past(state_q == S_IDLE) |-> $past(start_i))
    else $error("left idle without a start");

  // a scan runs to the last slot
  a_scan_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && !stat_i.idx_last |=> (state_q == S_SCAN))
    else $error("scan cut short");

endmodule

[rtl/core/hevc_ref_list_and_dpb_eviction_unit.sv]
// top level: reference list builder and picture table eviction picker
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------------------------
//  command   | start / busy                | command_i, slot_i, entry_valid_i, frame_*_i,
//            |                             | max_list0_i, max_list1_i
//  result    | result_valid_o (one cycle)  | list_select_o, ref_slot_o, entry_found_o,
//            |                             | use_default_o, last_o, list0/1_count_o
//  config    | cfg_we_i                    | cfg_wdata_i (ref_mode)
//
//  A write beat updates one slot and gives no result beat; legacy-mode commands give their beat in the next cycle.
//  Every slot scan walks the table one slot a cycle, over all N = DPB_SLOTS slots.
//  Random access: prep pass over the N slots, then one scan per list entry (level 2: short list).
//  Low delay: up to six lookup scans; eviction: up to two scans.
//  Reset clears the valid bits and the mode; results cannot be held off by the receiver.
module hevc_ref_list_and_dpb_eviction_unit
  import hrldu_pkg::*;
#(
  parameter int DPB_SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       command_i,
  input  logic [3:0]       slot_i,
  input  logic             entry_valid_i,
  input  logic [POC_W-1:0] frame_poc_i,
  input  logic [LVL_W-1:0] frame_level_i,
  input  logic [LVL_W-1:0] frame_temporal_id_i,
  input  logic [CNT_W-1:0] max_list0_i,
  input  logic [CNT_W-1:0] max_list1_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  output logic             result_valid_o,
  output logic             list_select_o,
  output logic [3:0]       ref_slot_o,
  output logic             entry_found_o,
  output logic             use_default_o,
  output logic             last_o,
  output logic [CNT_W-1:0] list0_count_o,
  output logic [CNT_W-1:0] list1_count_o
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  hrldu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .command_i   (command_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .ctl_o       (ctl),
    .busy_o      (busy)
  );

  hrldu_dpath #(
    .DPB_SLOTS (DPB_SLOTS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .stat_o              (stat),
    .slot_i              (slot_i),
    .entry_valid_i       (entry_valid_i),
    .frame_poc_i         (frame_poc_i),
    .frame_level_i       (frame_level_i),
    .frame_temporal_id_i (frame_temporal_id_i),
    .max_list0_i         (max_list0_i),
    .max_list1_i         (max_list1_i),
    .result_valid_o      (result_valid_o),
    .list_select_o       (list_select_o),
    .ref_slot_o          (ref_slot_o),
    .entry_found_o       (entry_found_o),
    .use_default_o       (use_default_o),
    .last_o              (last_o),
    .list0_count_o       (list0_count_o),
    .list1_count_o       (list1_count_o)
  );

endmodule
